@@ rtl/ostp_pkg.sv @@
// Shared types and constants for the one-shot timer pool.
package ostp_pkg;

    localparam int CMD_W      = 2;
    localparam int HANDLE_W   = 4;
    localparam int COUNT_W    = 16;
    localparam int TAG_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int MAX_REPORT = 16;
    localparam int REPORT_W   = $clog2(MAX_REPORT + 1);
    localparam logic [COUNT_W-1:0] PRESCALE_RESET = 16'd1000;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_NEW     = 2'd1,
        CMD_RECOUNT = 2'd2,
        CMD_CANCEL  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_IGNORED = 2'd2,
        ST_EXPIRED = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_PRESC_INC,
        OP_STEP,
        OP_DEC,
        OP_CUT,
        OP_FIRE,
        OP_POP,
        OP_ADV,
        OP_LINK1,
        OP_LINK2,
        OP_UNLINK,
        OP_FREEH,
        OP_RES
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status res_st;
    } t_dp_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic presc_ge;
        logic fhead_nil;
        logic cnt_zero;
        logic h_bad;
        logic cur_nil;
        logic old_le1;
        logic rem_gt_val;
        logic cur_eq_h;
        logic need_report;
        logic out_free;
    } t_dp_sts;

endpackage

@@ rtl/ostp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module ostp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ostp_ctrl.sv @@
// Sequencer for the timer pool: walks the running list one entry at a time.
module ostp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  ostp_pkg::t_dp_sts  i_sts,
    output ostp_pkg::t_dp_ctl  o_ctl
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_W_RD, S_W_EV, S_CUT, S_F_RD, S_F_EV,
        S_N_POP, S_I_RD, S_I_EV, S_L1, S_L2, S_M_RD, S_M_EV, S_C_FREE, S_RES
    } t_state;

    t_state            r_state, n_state;
    ostp_pkg::t_status r_res_st, n_res_st;
    logic              r_stall;

    always_comb begin
        n_state      = r_state;
        n_res_st     = r_res_st;
        o_ctl.op     = ostp_pkg::OP_NONE;
        o_ctl.res_st = r_res_st;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.op = ostp_pkg::OP_ACCEPT;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_sts.cmd)
                    ostp_pkg::CMD_TICK: begin
                        if (i_sts.presc_ge) begin
                            o_ctl.op = ostp_pkg::OP_STEP;
                            n_state  = S_W_RD;
                        end else begin
                            o_ctl.op = ostp_pkg::OP_PRESC_INC;
                            n_state  = S_IDLE;
                        end
                    end
                    ostp_pkg::CMD_NEW: begin
                        if (i_sts.fhead_nil) begin
                            n_res_st = ostp_pkg::ST_EMPTY;
                            n_state  = S_RES;
                        end else begin
                            n_state = S_N_POP;
                        end
                    end
                    ostp_pkg::CMD_RECOUNT: begin
                        if (i_sts.cnt_zero || i_sts.h_bad) begin
                            n_res_st = ostp_pkg::ST_IGNORED;
                            n_state  = S_RES;
                        end else begin
                            n_state = S_M_RD;
                        end
                    end
                    ostp_pkg::CMD_CANCEL: begin
                        if (i_sts.h_bad) begin
                            n_res_st = ostp_pkg::ST_IGNORED;
                            n_state  = S_RES;
                        end else begin
                            n_state = S_M_RD;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_W_RD: n_state = i_sts.cur_nil ? S_IDLE : S_W_EV;
            S_W_EV: begin
                o_ctl.op = ostp_pkg::OP_DEC;
                n_state  = i_sts.old_le1 ? S_CUT : S_W_RD;
            end
            S_CUT: begin
                o_ctl.op = ostp_pkg::OP_CUT;
                n_state  = S_F_RD;
            end
            S_F_RD: n_state = i_sts.cur_nil ? S_IDLE : S_F_EV;
            S_F_EV: begin
                if (!i_sts.need_report || i_sts.out_free) begin
                    o_ctl.op = ostp_pkg::OP_FIRE;
                    n_state  = S_F_RD;
                end
            end
            S_N_POP: begin
                o_ctl.op = ostp_pkg::OP_POP;
                n_state  = S_I_RD;
            end
            S_I_RD: n_state = i_sts.cur_nil ? S_L1 : S_I_EV;
            S_I_EV: begin
                if (i_sts.rem_gt_val) begin
                    o_ctl.op = ostp_pkg::OP_ADV;
                    n_state  = S_I_RD;
                end else begin
                    n_state = S_L1;
                end
            end
            S_L1: begin
                o_ctl.op = ostp_pkg::OP_LINK1;
                n_state  = S_L2;
            end
            S_L2: begin
                o_ctl.op = ostp_pkg::OP_LINK2;
                n_res_st = ostp_pkg::ST_OK;
                n_state  = S_RES;
            end
            S_M_RD: begin
                if (i_sts.cur_nil) begin
                    n_res_st = ostp_pkg::ST_IGNORED;
                    n_state  = S_RES;
                end else begin
                    n_state = S_M_EV;
                end
            end
            S_M_EV: begin
                if (i_sts.cur_eq_h) begin
                    o_ctl.op = ostp_pkg::OP_UNLINK;
                    n_state  = (i_sts.cmd == ostp_pkg::CMD_RECOUNT) ? S_I_RD : S_C_FREE;
                end else begin
                    o_ctl.op = ostp_pkg::OP_ADV;
                    n_state  = S_M_RD;
                end
            end
            S_C_FREE: begin
                o_ctl.op = ostp_pkg::OP_FREEH;
                n_res_st = ostp_pkg::ST_OK;
                n_state  = S_RES;
            end
            S_RES: begin
                if (i_sts.out_free) begin
                    o_ctl.op = ostp_pkg::OP_RES;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_res_st <= ostp_pkg::ST_OK;
            r_stall  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_res_st <= n_res_st;
            r_stall  <= (n_state != S_IDLE);
        end
    end

    assign o_stall = r_stall;

`ifndef SYNTH
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.op == ostp_pkg::OP_RES) |-> i_sts.out_free)
        else $error("result loaded into a full output register");
    a_fire_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.op == ostp_pkg::OP_FIRE && i_sts.need_report) |-> i_sts.out_free)
        else $error("expiry reported into a full output register");
    a_dec_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.op == ostp_pkg::OP_DEC || o_ctl.op == ostp_pkg::OP_FIRE) |-> !i_sts.cur_nil)
        else $error("list operation on null entry");
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("input open while busy");
`endif

endmodule

@@ rtl/ostp_dpath.sv @@
// Datapath of the timer pool: list stores, free stack, prescaler, result register.
module ostp_dpath #(
    parameter int TIMERS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ostp_pkg::t_dp_ctl               i_ctl,
    output ostp_pkg::t_dp_sts               o_sts,
    input  logic [ostp_pkg::CMD_W-1:0]      i_cmd,
    input  logic [ostp_pkg::HANDLE_W-1:0]   i_handle,
    input  logic [ostp_pkg::COUNT_W-1:0]    i_count,
    input  logic [ostp_pkg::TAG_W-1:0]      i_owner_tag,
    input  logic                            i_cfg_wr_en,
    input  logic [ostp_pkg::COUNT_W-1:0]    i_cfg_wr_data,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [ostp_pkg::STATUS_W-1:0]   o_status,
    output logic [ostp_pkg::HANDLE_W-1:0]   o_handle_res,
    output logic [ostp_pkg::TAG_W-1:0]      o_owner_tag_res,
    output logic                            o_last
);

    localparam int HW = $clog2(TIMERS + 1);
    localparam int AW = $clog2(TIMERS);
    localparam logic [HW-1:0] NIL = HW'(TIMERS);

    logic [HW-1:0]                    r_cur, r_prev, r_h, r_head, r_fhead, r_frd_addr;
    logic                             r_frd_ok;
    logic [TIMERS-1:0]                r_fvalid;
    ostp_pkg::t_cmd                   r_cmd;
    logic [ostp_pkg::HANDLE_W-1:0]    r_hin;
    logic [ostp_pkg::COUNT_W-1:0]     r_cnt, r_val, r_presc, r_limit;
    logic [ostp_pkg::TAG_W-1:0]       r_tag;
    logic [ostp_pkg::REPORT_W-1:0]    r_k;
    logic                             r_ovalid, r_last;
    logic [ostp_pkg::STATUS_W-1:0]    r_ostatus;
    logic [ostp_pkg::HANDLE_W-1:0]    r_ohandle;
    logic [ostp_pkg::TAG_W-1:0]       r_otag;

    logic [ostp_pkg::COUNT_W-1:0]     rem_q, rem_wdata;
    logic [ostp_pkg::TAG_W-1:0]       tag_q;
    logic [HW-1:0]                    rnext_q, fram_q, free_q, rnext_wdata;
    logic                             rem_we, tag_we, rnext_we, free_we;
    logic [AW-1:0]                    rem_waddr, tag_waddr, rnext_waddr, free_waddr;
    logic                             fvalid_at_head, out_free, need_report, fire_last;
    logic [ostp_pkg::HANDLE_W-1:0]    res_handle;

    ostp_ram #(.WIDTH(ostp_pkg::COUNT_W), .DEPTH(TIMERS)) u_rem_ram (
        .i_clk(i_clk), .i_we(rem_we), .i_waddr(rem_waddr), .i_wdata(rem_wdata),
        .i_raddr(r_cur[AW-1:0]), .o_rdata(rem_q)
    );
    ostp_ram #(.WIDTH(ostp_pkg::TAG_W), .DEPTH(TIMERS)) u_tag_ram (
        .i_clk(i_clk), .i_we(tag_we), .i_waddr(tag_waddr), .i_wdata(r_tag),
        .i_raddr(r_cur[AW-1:0]), .o_rdata(tag_q)
    );
    ostp_ram #(.WIDTH(HW), .DEPTH(TIMERS)) u_rnext_ram (
        .i_clk(i_clk), .i_we(rnext_we), .i_waddr(rnext_waddr), .i_wdata(rnext_wdata),
        .i_raddr(r_cur[AW-1:0]), .o_rdata(rnext_q)
    );
    ostp_ram #(.WIDTH(HW), .DEPTH(TIMERS)) u_free_ram (
        .i_clk(i_clk), .i_we(free_we), .i_waddr(free_waddr), .i_wdata(r_fhead),
        .i_raddr(r_fhead[AW-1:0]), .o_rdata(fram_q)
    );

    // untouched free-list entries read as their reset chain i -> i+1
    assign fvalid_at_head = (32'(r_fhead) < 32'(TIMERS)) ? r_fvalid[r_fhead[AW-1:0]] : 1'b0;
    assign free_q      = r_frd_ok ? fram_q : HW'(r_frd_addr + 1'b1);
    assign out_free    = !r_ovalid || !i_stall;
    assign need_report = (32'(r_k) < 32'(ostp_pkg::MAX_REPORT));
    assign fire_last   = (rnext_q == NIL) || (32'(r_k) == 32'(ostp_pkg::MAX_REPORT - 1));
    assign res_handle  = (i_ctl.res_st == ostp_pkg::ST_EMPTY) ? '0 :
                         (r_cmd == ostp_pkg::CMD_NEW) ? ostp_pkg::HANDLE_W'(r_h) : r_hin;

    always_comb begin
        rem_we      = 1'b0;
        rem_waddr   = r_h[AW-1:0];
        rem_wdata   = r_val;
        tag_we      = 1'b0;
        tag_waddr   = r_h[AW-1:0];
        rnext_we    = 1'b0;
        rnext_waddr = r_prev[AW-1:0];
        rnext_wdata = NIL;
        free_we     = 1'b0;
        free_waddr  = r_h[AW-1:0];
        unique case (i_ctl.op)
            ostp_pkg::OP_DEC: begin
                rem_we    = 1'b1;
                rem_waddr = r_cur[AW-1:0];
                rem_wdata = (rem_q != '0) ? rem_q - 1'b1 : '0;
            end
            ostp_pkg::OP_CUT: begin
                rnext_we = (r_prev != NIL);
            end
            ostp_pkg::OP_FIRE: begin
                free_we    = 1'b1;
                free_waddr = r_cur[AW-1:0];
            end
            ostp_pkg::OP_POP: begin
                rem_we = 1'b1;
                tag_we = 1'b1;
            end
            ostp_pkg::OP_LINK1: begin
                rnext_we    = 1'b1;
                rnext_waddr = r_h[AW-1:0];
                rnext_wdata = r_cur;
            end
            ostp_pkg::OP_LINK2: begin
                rnext_we    = (r_prev != NIL);
                rnext_wdata = r_h;
            end
            ostp_pkg::OP_UNLINK: begin
                rnext_we    = (r_prev != NIL);
                rnext_wdata = rnext_q;
                rem_we      = (r_cmd == ostp_pkg::CMD_RECOUNT);
                rem_wdata   = r_cnt;
            end
            ostp_pkg::OP_FREEH: begin
                free_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= NIL;
            r_fhead  <= '0;
            r_fvalid <= '0;
            r_presc  <= '0;
            r_limit  <= ostp_pkg::PRESCALE_RESET;
            r_ovalid <= 1'b0;
            r_frd_ok <= 1'b0;
        end else begin
            r_frd_addr <= r_fhead;
            r_frd_ok   <= fvalid_at_head;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (i_ctl.op)
                ostp_pkg::OP_ACCEPT: begin
                    r_cmd  <= ostp_pkg::t_cmd'(i_cmd);
                    r_hin  <= i_handle;
                    r_cnt  <= i_count;
                    r_tag  <= i_owner_tag;
                    r_val  <= (i_count == 16'd1) ? 16'd2 : i_count;
                    r_h    <= (ostp_pkg::t_cmd'(i_cmd) == ostp_pkg::CMD_NEW) ?
                              r_fhead : HW'(i_handle);
                    r_cur  <= r_head;
                    r_prev <= NIL;
                    r_k    <= '0;
                end
                ostp_pkg::OP_PRESC_INC: r_presc <= r_presc + 1'b1;
                ostp_pkg::OP_STEP:      r_presc <= '0;
                ostp_pkg::OP_DEC: begin
                    if (rem_q > 16'd1) begin
                        r_prev <= r_cur;
                        r_cur  <= rnext_q;
                    end
                end
                ostp_pkg::OP_CUT: begin
                    if (r_prev == NIL) begin
                        r_head <= NIL;
                    end
                end
                ostp_pkg::OP_FIRE: begin
                    if (need_report) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= ostp_pkg::ST_EXPIRED;
                        r_ohandle <= ostp_pkg::HANDLE_W'(r_cur);
                        r_otag    <= tag_q;
                        r_last    <= fire_last;
                        r_k       <= r_k + 1'b1;
                    end
                    r_fvalid[r_cur[AW-1:0]] <= 1'b1;
                    r_fhead <= r_cur;
                    r_cur   <= rnext_q;
                end
                ostp_pkg::OP_POP:  r_fhead <= free_q;
                ostp_pkg::OP_ADV: begin
                    r_prev <= r_cur;
                    r_cur  <= rnext_q;
                end
                ostp_pkg::OP_LINK1: begin
                end
                ostp_pkg::OP_LINK2: begin
                    if (r_prev == NIL) begin
                        r_head <= r_h;
                    end
                end
                ostp_pkg::OP_UNLINK: begin
                    if (r_prev == NIL) begin
                        r_head <= rnext_q;
                        r_cur  <= rnext_q;
                    end else begin
                        r_cur <= r_head;
                    end
                    r_prev <= NIL;
                    r_val  <= r_cnt;
                end
                ostp_pkg::OP_FREEH: begin
                    r_fvalid[r_h[AW-1:0]] <= 1'b1;
                    r_fhead <= r_h;
                end
                ostp_pkg::OP_RES: begin
                    r_ovalid  <= 1'b1;
                    r_ostatus <= i_ctl.res_st;
                    r_ohandle <= res_handle;
                    r_otag    <= '0;
                    r_last    <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_sts.cmd         = r_cmd;
    assign o_sts.presc_ge    = (r_presc >= r_limit);
    assign o_sts.fhead_nil   = (r_fhead == NIL);
    assign o_sts.cnt_zero    = (r_cnt == '0);
    assign o_sts.h_bad       = (32'(r_hin) >= 32'(TIMERS));
    assign o_sts.cur_nil     = (r_cur == NIL);
    assign o_sts.old_le1     = (rem_q <= 16'd1);
    assign o_sts.rem_gt_val  = (rem_q > r_val);
    assign o_sts.cur_eq_h    = (r_cur == r_h);
    assign o_sts.need_report = need_report;
    assign o_sts.out_free    = out_free;

    assign o_valid         = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_handle_res    = r_ohandle;
    assign o_owner_tag_res = r_otag;
    assign o_last          = r_last;

endmodule

@@ rtl/one_shot_timer_pool_unit.sv @@
// One-shot timer pool: a sorted running list and a LIFO free stack of handles.
// A tick without a prescaler step only advances the prescaler; other transactions walk
// the running list entry by entry (a recount looks its entry up, then inserts it again).
// Each list step is one registered read of the link/count memories and one compare.
// One transaction is in work at a time; results wait in an output register.
// Reset (synchronous, active low): list empty, free stack 0..TIMERS-1, prescaler 0, limit 1000.
module one_shot_timer_pool_unit #(
    parameter int TIMERS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [ostp_pkg::CMD_W-1:0]      i_cmd,
    input  logic [ostp_pkg::HANDLE_W-1:0]   i_handle,
    input  logic [ostp_pkg::COUNT_W-1:0]    i_count,
    input  logic [ostp_pkg::TAG_W-1:0]      i_owner_tag,
    input  logic                            i_cfg_wr_en,
    input  logic [ostp_pkg::COUNT_W-1:0]    i_cfg_wr_data,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [ostp_pkg::STATUS_W-1:0]   o_status,
    output logic [ostp_pkg::HANDLE_W-1:0]   o_handle_res,
    output logic [ostp_pkg::TAG_W-1:0]      o_owner_tag_res,
    output logic                            o_last
);

    ostp_pkg::t_dp_ctl ctl;
    ostp_pkg::t_dp_sts sts;

    ostp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    ostp_dpath #(.TIMERS(TIMERS)) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .i_cmd           (i_cmd),
        .i_handle        (i_handle),
        .i_count         (i_count),
        .i_owner_tag     (i_owner_tag),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_handle_res    (o_handle_res),
        .o_owner_tag_res (o_owner_tag_res),
        .o_last          (o_last)
    );

endmodule
